/* design/gmd_pkg.sv */
// package for the grid maze depth-first solver
// shared constants, opcodes and controller/datapath command and status types
package gmd_pkg;

	localparam int MaxCols = 16;
	localparam int MaxRows = 16;
	localparam int ColW = $clog2(MaxCols);
	localparam int RowW = $clog2(MaxRows);
	localparam int CellW = ColW + RowW;
	localparam int Cells = MaxCols * MaxRows;
	localparam int DepthW = CellW + 1;

	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_SOLVE = 2'd1;
	localparam logic [1:0] OP_READ = 2'd2;

	localparam logic [1:0] DIR_LEFT = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_UP = 2'd2;
	localparam logic [1:0] DIR_DOWN = 2'd3;

	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_START_COL = 3'd2;
	localparam logic [2:0] REG_START_ROW = 3'd3;
	localparam logic [2:0] REG_GOAL_COL = 3'd4;
	localparam logic [2:0] REG_GOAL_ROW = 3'd5;

	// controller to datapath commands
	typedef struct packed {
		logic wall_wr;      // write walls of request cell
		logic init;         // start a solve: load start cell, clear depth/found
		logic clr_step;     // clear one visited entry at the sweep address
		logic fetch;        // read walls of current cell
		logic vis_rd;       // read visited entry of candidate neighbour
		logic push;         // move to candidate, push direction
		logic pop_rd;       // read top of stack
		logic pop;          // step back using popped direction
		logic set_found;
		logic path_rd;      // read direction stack at step index
		logic load_out;     // latch result
		logic rd_valid;     // result is a valid path read; with fetch, skip to the next try
	} gmd_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic start_out;    // start cell lies outside the grid
		logic at_goal;
		logic clr_done;
		logic try_ok;       // current try passes wall, edge and depth checks
		logic [1:0] try_dir;
		logic tries_left;   // try_dir has not run past down
		logic vis_hit;      // registered visited read
		logic depth_zero;
		logic idx_ok;
	} gmd_sts_t;

endpackage

/* design/grid_maze_dfs_solver_core.sv */
// channel  | group  | contents
// request  | s_axis | tdata: op[1:0] cell_col[5:2] cell_row[9:6] wall_bits[13:10] step_index[21:14]
// result   | m_axis | tdata: path_found[0] path_length[8:1] step_direction[10:9] step_valid[11]
// config   | cfg    | cfg_we, cfg_index[2:0], cfg_data[4:0]
// writes and unused ops load the result from the output state; reads pass a read state first.
// a solve first sweeps the visited map clear, then per try either fetches the walls again when blocked,
// reads the visited map for a free neighbour, pushes to move, or pops the stack to step back.
// one request at a time; s_axis_tready is low until the result is loaded.
// arst_n clears control state; the wall store is undefined until written.
// a held m_axis_tready low stalls the block in its output state while a previous result is unread.
module grid_maze_dfs_solver_core (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [4:0] cfg_data,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // op, cell_col, cell_row, wall_bits, step_index
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [15:0] m_axis_tdata   // path_found, path_length, step_direction, step_valid
);

	logic [4:0] width_q, height_q;
	logic [3:0] start_col_q, start_row_q, goal_col_q, goal_row_q;
	gmd_pkg::gmd_cmd_t cmd;
	gmd_pkg::gmd_sts_t sts;
	logic path_found, step_valid;
	logic [7:0] path_length;
	logic [1:0] step_direction;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 5'd16;
			height_q <= 5'd16;
			start_col_q <= 4'd0;
			start_row_q <= 4'd0;
			goal_col_q <= 4'd15;
			goal_row_q <= 4'd15;
		end else if (cfg_we) begin
			case (cfg_index)
				gmd_pkg::REG_WIDTH: width_q <= cfg_data;
				gmd_pkg::REG_HEIGHT: height_q <= cfg_data;
				gmd_pkg::REG_START_COL: start_col_q <= cfg_data[3:0];
				gmd_pkg::REG_START_ROW: start_row_q <= cfg_data[3:0];
				gmd_pkg::REG_GOAL_COL: goal_col_q <= cfg_data[3:0];
				gmd_pkg::REG_GOAL_ROW: goal_row_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	gmd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.op(s_axis_tdata[1:0]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.cmd(cmd), .sts(sts)
	);

	gmd_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.maze_width(width_q), .maze_height(height_q),
		.start_col(start_col_q), .start_row(start_row_q),
		.goal_col(goal_col_q), .goal_row(goal_row_q),
		.cell_col(s_axis_tdata[5:2]), .cell_row(s_axis_tdata[9:6]),
		.wall_bits(s_axis_tdata[13:10]), .step_index(s_axis_tdata[21:14]),
		.path_found(path_found), .path_length(path_length),
		.step_direction(step_direction), .step_valid(step_valid)
	);

	assign m_axis_tdata = {4'd0, step_valid, step_direction, path_length, path_found};

endmodule

/* design/gmd_datapath.sv */
// datapath of the maze solver: wall store, visited map, direction stack and position
// depends on gmd_pkg for widths and command/status types
module gmd_datapath (
	input  logic clk,
	input  logic arst_n,
	input  gmd_pkg::gmd_cmd_t cmd,
	output gmd_pkg::gmd_sts_t sts,
	input  logic [4:0] maze_width,
	input  logic [4:0] maze_height,
	input  logic [3:0] start_col,
	input  logic [3:0] start_row,
	input  logic [3:0] goal_col,
	input  logic [3:0] goal_row,
	input  logic [3:0] cell_col,
	input  logic [3:0] cell_row,
	input  logic [3:0] wall_bits,
	input  logic [7:0] step_index,
	output logic path_found,
	output logic [7:0] path_length,
	output logic [1:0] step_direction,
	output logic step_valid
);

	logic [3:0] wall_mem [gmd_pkg::Cells];
	logic visit_mem [gmd_pkg::Cells];
	logic [1:0] dir_mem [gmd_pkg::Cells];

	logic [gmd_pkg::ColW-1:0] cur_col_q;
	logic [gmd_pkg::RowW-1:0] cur_row_q;
	logic [gmd_pkg::DepthW-1:0] depth_q;
	logic found_q;
	logic [gmd_pkg::CellW:0] clr_q;
	logic [3:0] walls_q;
	logic [2:0] try_q;
	logic vis_q;
	logic [1:0] pop_dir_q;
	logic [1:0] path_dir_q;

	logic [4:0] eff_w, eff_h;
	logic [gmd_pkg::ColW:0] nb_col;
	logic [gmd_pkg::RowW:0] nb_row;
	logic edge_ok;
	logic [gmd_pkg::CellW-1:0] cur_addr, nb_addr, st_addr;

	// effective grid size, 0 acts as 1 and sizes above 16 act as 16
	always_comb begin
		eff_w = (maze_width == 5'd0) ? 5'd1 :
			(maze_width > 5'(gmd_pkg::MaxCols)) ? 5'(gmd_pkg::MaxCols) : maze_width;
		eff_h = (maze_height == 5'd0) ? 5'd1 :
			(maze_height > 5'(gmd_pkg::MaxRows)) ? 5'(gmd_pkg::MaxRows) : maze_height;
	end

	// neighbour of the current cell in the try direction
	always_comb begin
		nb_col = {1'b0, cur_col_q};
		nb_row = {1'b0, cur_row_q};
		edge_ok = 1'b0;
		case (try_q[1:0])
			gmd_pkg::DIR_LEFT: begin
				edge_ok = (cur_col_q != '0);
				nb_col = {1'b0, cur_col_q} - 1'b1;
			end
			gmd_pkg::DIR_RIGHT: begin
				nb_col = {1'b0, cur_col_q} + 1'b1;
				edge_ok = (5'(nb_col) < eff_w);
			end
			gmd_pkg::DIR_UP: begin
				edge_ok = (cur_row_q != '0);
				nb_row = {1'b0, cur_row_q} - 1'b1;
			end
			default: begin
				nb_row = {1'b0, cur_row_q} + 1'b1;
				edge_ok = (5'(nb_row) < eff_h);
			end
		endcase
	end

	assign cur_addr = {cur_row_q, cur_col_q};
	assign nb_addr = {nb_row[gmd_pkg::RowW-1:0], nb_col[gmd_pkg::ColW-1:0]};
	assign st_addr = depth_q[gmd_pkg::CellW-1:0] - 1'b1;

	always_comb begin
		sts.start_out = (5'(start_col) >= eff_w) || (5'(start_row) >= eff_h);
		sts.at_goal = (cur_col_q == goal_col) && (cur_row_q == goal_row);
		sts.clr_done = clr_q[gmd_pkg::CellW];
		sts.try_ok = !walls_q[try_q[1:0]] && edge_ok &&
			(depth_q < gmd_pkg::DepthW'(gmd_pkg::Cells));
		sts.try_dir = try_q[1:0];
		sts.tries_left = !try_q[2];
		sts.vis_hit = vis_q;
		sts.depth_zero = (depth_q == '0);
		sts.idx_ok = (gmd_pkg::DepthW'(step_index) < depth_q);
	end

	// wall store
	always_ff @(posedge clk) begin
		if (cmd.wall_wr)
			wall_mem[{cell_row, cell_col}] <= wall_bits;
		if (cmd.fetch)
			walls_q <= wall_mem[cur_addr];
	end

	// visited map: sweep clear, mark start on init, mark on move, read candidate
	always_ff @(posedge clk) begin
		if (cmd.clr_step)
			visit_mem[clr_q[gmd_pkg::CellW-1:0]] <= 1'b0;
		else if (cmd.init)
			visit_mem[{start_row, start_col}] <= 1'b1;
		else if (cmd.push)
			visit_mem[nb_addr] <= 1'b1;
		if (cmd.vis_rd)
			vis_q <= visit_mem[nb_addr];
	end

	// direction stack
	always_ff @(posedge clk) begin
		if (cmd.push)
			dir_mem[depth_q[gmd_pkg::CellW-1:0]] <= try_q[1:0];
		if (cmd.pop_rd)
			pop_dir_q <= dir_mem[st_addr];
		if (cmd.path_rd)
			path_dir_q <= dir_mem[step_index];
	end

	// position, depth, found flag, try counter and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_col_q <= '0;
			cur_row_q <= '0;
			depth_q <= '0;
			found_q <= 1'b0;
			clr_q <= '0;
			try_q <= '0;
		end else begin
			if (cmd.clr_step)
				clr_q <= clr_q + 1'b1;
			if (cmd.init) begin
				cur_col_q <= start_col;
				cur_row_q <= start_row;
				depth_q <= '0;
				found_q <= 1'b0;
				clr_q <= '0;
				try_q <= '0;
			end
			if (cmd.push) begin
				cur_col_q <= nb_col[gmd_pkg::ColW-1:0];
				cur_row_q <= nb_row[gmd_pkg::RowW-1:0];
				depth_q <= depth_q + 1'b1;
				try_q <= '0;
			end
			if (cmd.pop) begin
				depth_q <= depth_q - 1'b1;
				try_q <= {1'b0, pop_dir_q} + 3'd1;
				case (pop_dir_q)
					gmd_pkg::DIR_LEFT: cur_col_q <= cur_col_q + 1'b1;
					gmd_pkg::DIR_RIGHT: cur_col_q <= cur_col_q - 1'b1;
					gmd_pkg::DIR_UP: cur_row_q <= cur_row_q + 1'b1;
					default: cur_row_q <= cur_row_q - 1'b1;
				endcase
			end
			if (cmd.set_found)
				found_q <= 1'b1;
			// skipped try: advance to the next direction
			if (cmd.fetch && cmd.rd_valid)
				try_q <= try_q + 3'd1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_found <= 1'b0;
			path_length <= '0;
			step_direction <= '0;
			step_valid <= 1'b0;
		end else if (cmd.load_out) begin
			path_found <= found_q;
			path_length <= (depth_q > 9'd255) ? 8'd255 : depth_q[7:0];
			step_direction <= cmd.rd_valid ? path_dir_q : 2'd0;
			step_valid <= cmd.rd_valid;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |=> depth_q == $past(depth_q) + 1'b1)
		else $error("depth did not grow on push");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> depth_q != '0)
		else $error("pop from empty stack");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop together");

endmodule

/* design/gmd_ctrl.sv */
// controller state machine of the maze solver: handshake and solve sequencing
// depends on gmd_pkg for opcodes and command/status types
module gmd_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [1:0] op,
	output logic out_valid,
	input  logic out_ready,
	output gmd_pkg::gmd_cmd_t cmd,
	input  gmd_pkg::gmd_sts_t sts
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLEAR = 4'd1;
	localparam logic [3:0] ST_INIT = 4'd2;
	localparam logic [3:0] ST_CHECK = 4'd3;
	localparam logic [3:0] ST_FETCH = 4'd4;
	localparam logic [3:0] ST_TRY = 4'd5;
	localparam logic [3:0] ST_VIS = 4'd6;
	localparam logic [3:0] ST_POPRD = 4'd7;
	localparam logic [3:0] ST_POP = 4'd8;
	localparam logic [3:0] ST_READ = 4'd9;
	localparam logic [3:0] ST_OUT = 4'd10;

	logic [3:0] state_q, state_d;
	logic rd_ok_q, rd_ok_d;
	logic out_valid_q;
	logic accept, out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		rd_ok_d = rd_ok_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rd_ok_d = 1'b0;
					if (op == gmd_pkg::OP_SOLVE) begin
						cmd.init = 1'b1;
						state_d = ST_CLEAR;
					end else if (op == gmd_pkg::OP_READ) begin
						cmd.path_rd = 1'b1;
						rd_ok_d = sts.idx_ok;
						state_d = ST_READ;
					end else begin
						cmd.wall_wr = (op == gmd_pkg::OP_WRITE);
						state_d = ST_OUT;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (&{1'b1, sts.clr_done} && sts.clr_done)
					state_d = ST_INIT;
			end
			ST_INIT: begin
				if (sts.start_out) begin
					state_d = ST_OUT;
				end else begin
					cmd.init = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.at_goal) begin
					cmd.set_found = 1'b1;
					state_d = ST_OUT;
				end else begin
					cmd.fetch = 1'b1;
					state_d = ST_TRY;
				end
			end
			ST_FETCH: begin
				cmd.fetch = 1'b1;
				state_d = ST_TRY;
			end
			ST_TRY: begin
				if (!sts.tries_left) begin
					state_d = sts.depth_zero ? ST_OUT : ST_POPRD;
				end else if (sts.try_ok) begin
					cmd.vis_rd = 1'b1;
					state_d = ST_VIS;
				end else begin
					cmd.fetch = 1'b1;
					cmd.rd_valid = 1'b1;
				end
			end
			ST_VIS: begin
				if (sts.vis_hit) begin
					cmd.fetch = 1'b1;
					cmd.rd_valid = 1'b1;
					state_d = ST_TRY;
				end else begin
					cmd.push = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_POPRD: begin
				cmd.pop_rd = 1'b1;
				state_d = ST_POP;
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_FETCH;
			end
			ST_READ: state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					cmd.rd_valid = rd_ok_q;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rd_ok_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_ok_q <= rd_ok_d;
			if (cmd.load_out)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> state_q == ST_OUT)
		else $error("result loaded outside output state");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("accepted while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> state_q == ST_VIS && !sts.vis_hit)
		else $error("move into visited cell");

endmodule
